/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the scroll unit.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define VRPSU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define VRPSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/vrpsu_pkg.sv */
// Package of the video register port and scroll unit: action codes,
// register numbers and fixed constants. No dependencies.
`default_nettype none

package vrpsu_pkg;

    // Step actions.
    localparam logic [2:0] ACT_READ       = 3'd0;
    localparam logic [2:0] ACT_WRITE      = 3'd1;
    localparam logic [2:0] ACT_INC_X      = 3'd2;
    localparam logic [2:0] ACT_INC_Y      = 3'd3;
    localparam logic [2:0] ACT_COPY_X     = 3'd4;
    localparam logic [2:0] ACT_COPY_Y     = 3'd5;
    localparam logic [2:0] ACT_SET_STAT   = 3'd6;
    localparam logic [2:0] ACT_CLEAR_STAT = 3'd7;

    // Processor-visible register numbers.
    localparam logic [2:0] REG_CONTROL   = 3'd0;
    localparam logic [2:0] REG_MASK      = 3'd1;
    localparam logic [2:0] REG_STATUS    = 3'd2;
    localparam logic [2:0] REG_ATTR_ADDR = 3'd3;
    localparam logic [2:0] REG_ATTR_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL    = 3'd5;
    localparam logic [2:0] REG_ADDRESS   = 3'd6;
    localparam logic [2:0] REG_DATA      = 3'd7;

    // Start of the palette region in the 14-bit memory map.
    localparam logic [13:0] PALETTE_BASE = 14'h3F00;

    // Coarse Y rows: the last visible row and the last encodable row.
    localparam logic [4:0] COARSE_Y_LAST_ROW = 5'd29;
    localparam logic [4:0] COARSE_MAX        = 5'd31;
    localparam logic [2:0] FINE_Y_MAX        = 3'd7;

    localparam logic [14:0] ADDR_STEP_ROW  = 15'd32;
    localparam logic [14:0] ADDR_STEP_BYTE = 15'd1;

endpackage

`default_nettype wire

/* rtl/video_register_port_scroll_unit.sv */
// Video register port and scroll unit: processor register file, loopy
// scroll/address registers and sprite attribute store. Uses vrpsu_pkg.
//
// Usage: one input channel (s_) carries a step: a processor read or write of
// one of eight registers, or a render-timing event (increment X/Y, copy X/Y,
// set or clear status flags). The result channel (m_) carries exactly one
// result per step: read data, the memory address and strobes of a data-port
// access, the NMI pulse, and the current address and fine X after the step.
// The result is registered: a step transferred in one cycle shows its result
// in the next. Throughput is one step per cycle; the only state that limits it
// is the single output register, which is refilled in the same cycle that
// its result is transferred. When the receiver stalls, the output register
// holds and s_ready falls until the result is taken.
// The 256-byte attribute store is a memory read every cycle at the next
// attribute pointer, so its registered data is ready when a read arrives.
// Reset (synchronous, active low) clears the state registers, not the output
// data, and the 256 per-entry valid bits at once; an unwritten attribute entry
// reads as zero. No clearing pass runs, so a step can be accepted right away.
`default_nettype none

module video_register_port_scroll_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_action,
    input  wire logic [2:0]  s_reg_index,
    input  wire logic [7:0]  s_write_data,
    input  wire logic [7:0]  s_mem_byte,
    input  wire logic [2:0]  s_status_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data,
    output logic [13:0]      m_mem_addr,
    output logic             m_mem_write,
    output logic             m_mem_read,
    output logic             m_nmi_pulse,
    output logic [14:0]      m_cur_addr,
    output logic [2:0]       m_fine_scroll_x
);

    // Architectural state.
    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  read_buffer_reg, read_buffer_next;
    logic        toggle_reg, toggle_next;
    logic [14:0] temp_addr_reg, temp_addr_next;
    logic [14:0] cur_addr_reg, cur_addr_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic [7:0]  attr_ptr_reg, attr_ptr_next;

    // Attribute store and its per-entry valid bits.
    logic [7:0]   attr_mem [256];
    logic [255:0] attr_valid_reg;
    logic [7:0]   attr_rd_reg;
    logic         attr_rd_valid_reg;
    logic         attr_we;

    // Output register.
    logic        out_valid_reg;
    logic [7:0]  read_data_reg, read_data_next;
    logic [13:0] mem_addr_reg, mem_addr_next;
    logic        mem_write_reg, mem_write_next;
    logic        mem_read_reg, mem_read_next;
    logic        nmi_reg, nmi_next;

    logic        accept;
    logic        rendering;
    logic [14:0] addr_step;
    logic [4:0]  coarse_y;

    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign rendering = mask_reg[3] || mask_reg[4];
    assign addr_step = control_reg[2] ? vrpsu_pkg::ADDR_STEP_ROW : vrpsu_pkg::ADDR_STEP_BYTE;
    assign coarse_y  = cur_addr_reg[9:5];

    always_comb begin
        control_next     = control_reg;
        mask_next        = mask_reg;
        status_next      = status_reg;
        read_buffer_next = read_buffer_reg;
        toggle_next      = toggle_reg;
        temp_addr_next   = temp_addr_reg;
        cur_addr_next    = cur_addr_reg;
        fine_x_next      = fine_x_reg;
        attr_ptr_next    = attr_ptr_reg;
        attr_we          = 1'b0;
        read_data_next   = 8'd0;
        mem_addr_next    = 14'd0;
        mem_write_next   = 1'b0;
        mem_read_next    = 1'b0;
        nmi_next         = 1'b0;

        if (accept) begin
            case (s_action)
                vrpsu_pkg::ACT_READ: begin
                    case (s_reg_index)
                        vrpsu_pkg::REG_STATUS: begin
                            read_data_next = {status_reg, read_buffer_reg[4:0]};
                            status_next    = {1'b0, status_reg[1:0]};
                            toggle_next    = 1'b0;
                        end
                        vrpsu_pkg::REG_ATTR_DATA: begin
                            read_data_next = attr_rd_valid_reg ? attr_rd_reg : 8'd0;
                        end
                        vrpsu_pkg::REG_DATA: begin
                            mem_addr_next    = cur_addr_reg[13:0];
                            mem_read_next    = 1'b1;
                            // Palette reads bypass the delayed buffer.
                            read_data_next   = (cur_addr_reg[13:0] >= vrpsu_pkg::PALETTE_BASE)
                                               ? s_mem_byte : read_buffer_reg;
                            read_buffer_next = s_mem_byte;
                            cur_addr_next    = cur_addr_reg + addr_step;
                        end
                        default: begin
                        end
                    endcase
                end
                vrpsu_pkg::ACT_WRITE: begin
                    case (s_reg_index)
                        vrpsu_pkg::REG_CONTROL: begin
                            control_next          = s_write_data;
                            temp_addr_next[11:10] = s_write_data[1:0];
                        end
                        vrpsu_pkg::REG_MASK: begin
                            mask_next = s_write_data;
                        end
                        vrpsu_pkg::REG_ATTR_ADDR: begin
                            attr_ptr_next = s_write_data;
                        end
                        vrpsu_pkg::REG_ATTR_DATA: begin
                            attr_we       = 1'b1;
                            attr_ptr_next = attr_ptr_reg + 8'd1;
                        end
                        vrpsu_pkg::REG_SCROLL: begin
                            if (!toggle_reg) begin
                                fine_x_next         = s_write_data[2:0];
                                temp_addr_next[4:0] = s_write_data[7:3];
                            end else begin
                                temp_addr_next[14:12] = s_write_data[2:0];
                                temp_addr_next[9:5]   = s_write_data[7:3];
                            end
                            toggle_next = !toggle_reg;
                        end
                        vrpsu_pkg::REG_ADDRESS: begin
                            if (!toggle_reg) begin
                                temp_addr_next[14]   = 1'b0;
                                temp_addr_next[13:8] = s_write_data[5:0];
                            end else begin
                                temp_addr_next[7:0] = s_write_data;
                                cur_addr_next       = {temp_addr_reg[14:8], s_write_data};
                            end
                            toggle_next = !toggle_reg;
                        end
                        vrpsu_pkg::REG_DATA: begin
                            mem_addr_next  = cur_addr_reg[13:0];
                            mem_write_next = 1'b1;
                            cur_addr_next  = cur_addr_reg + addr_step;
                        end
                        default: begin
                        end
                    endcase
                end
                vrpsu_pkg::ACT_INC_X: begin
                    if (rendering) begin
                        if (cur_addr_reg[4:0] == vrpsu_pkg::COARSE_MAX) begin
                            cur_addr_next[4:0] = 5'd0;
                            cur_addr_next[10]  = !cur_addr_reg[10];
                        end else begin
                            cur_addr_next[4:0] = cur_addr_reg[4:0] + 5'd1;
                        end
                    end
                end
                vrpsu_pkg::ACT_INC_Y: begin
                    if (rendering) begin
                        if (cur_addr_reg[14:12] != vrpsu_pkg::FINE_Y_MAX) begin
                            cur_addr_next[14:12] = cur_addr_reg[14:12] + 3'd1;
                        end else begin
                            cur_addr_next[14:12] = 3'd0;
                            // The last visible row wraps to the next nametable;
                            // the attribute rows wrap in place.
                            if (coarse_y == vrpsu_pkg::COARSE_Y_LAST_ROW) begin
                                cur_addr_next[9:5] = 5'd0;
                                cur_addr_next[11]  = !cur_addr_reg[11];
                            end else if (coarse_y == vrpsu_pkg::COARSE_MAX) begin
                                cur_addr_next[9:5] = 5'd0;
                            end else begin
                                cur_addr_next[9:5] = coarse_y + 5'd1;
                            end
                        end
                    end
                end
                vrpsu_pkg::ACT_COPY_X: begin
                    if (rendering) begin
                        cur_addr_next[10]  = temp_addr_reg[10];
                        cur_addr_next[4:0] = temp_addr_reg[4:0];
                    end
                end
                vrpsu_pkg::ACT_COPY_Y: begin
                    if (rendering) begin
                        cur_addr_next[14:11] = temp_addr_reg[14:11];
                        cur_addr_next[9:5]   = temp_addr_reg[9:5];
                    end
                end
                vrpsu_pkg::ACT_SET_STAT: begin
                    status_next = status_reg | s_status_bits;
                    nmi_next    = s_status_bits[2] && control_reg[7];
                end
                vrpsu_pkg::ACT_CLEAR_STAT: begin
                    status_next = status_reg & ~s_status_bits;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg       <= 8'd0;
            mask_reg          <= 8'd0;
            status_reg        <= 3'd0;
            read_buffer_reg   <= 8'd0;
            toggle_reg        <= 1'b0;
            temp_addr_reg     <= 15'd0;
            cur_addr_reg      <= 15'd0;
            fine_x_reg        <= 3'd0;
            attr_ptr_reg      <= 8'd0;
            attr_valid_reg    <= '0;
            attr_rd_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            control_reg     <= control_next;
            mask_reg        <= mask_next;
            status_reg      <= status_next;
            read_buffer_reg <= read_buffer_next;
            toggle_reg      <= toggle_next;
            temp_addr_reg   <= temp_addr_next;
            cur_addr_reg    <= cur_addr_next;
            fine_x_reg      <= fine_x_next;
            attr_ptr_reg    <= attr_ptr_next;
            if (attr_we) begin
                attr_valid_reg[attr_ptr_reg] <= 1'b1;
            end
            // A write always moves the pointer, so the entry read here is never
            // the one written in the same cycle.
            attr_rd_valid_reg <= attr_valid_reg[attr_ptr_next];
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (attr_we) begin
            attr_mem[attr_ptr_reg] <= s_write_data;
        end
        attr_rd_reg <= attr_mem[attr_ptr_next];
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            read_data_reg <= read_data_next;
            mem_addr_reg  <= mem_addr_next;
            mem_write_reg <= mem_write_next;
            mem_read_reg  <= mem_read_next;
            nmi_reg       <= nmi_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_read_data     = read_data_reg;
    assign m_mem_addr      = mem_addr_reg;
    assign m_mem_write     = mem_write_reg;
    assign m_mem_read      = mem_read_reg;
    assign m_nmi_pulse     = nmi_reg;
    assign m_cur_addr      = cur_addr_reg;
    assign m_fine_scroll_x = fine_x_reg;

endmodule

`default_nettype wire

/* rtl/vrpsu_checker.sv */
// Port-level checker for the video register port and scroll unit, bound to
// the top level. Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vrpsu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_read_data,
    input wire logic [13:0] m_mem_addr,
    input wire logic        m_mem_write,
    input wire logic        m_mem_read
);

    `VRPSU_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `VRPSU_ASSERT(a_one_cycle_latency, aclk, aresetn, s_valid && s_ready |=> m_valid, "transfer without result next cycle")
    `VRPSU_ASSERT(a_stall_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_mem_addr) && $stable(m_read_data), "stalled result changed")
    `VRPSU_ASSERT(a_strobes_exclusive, aclk, aresetn, m_valid |-> !(m_mem_write && m_mem_read), "memory read and write together")
    `VRPSU_ASSERT(a_addr_only_on_access, aclk, aresetn, m_valid && !m_mem_write && !m_mem_read |-> m_mem_addr == 14'd0, "address without data-port access")

endmodule

bind video_register_port_scroll_unit vrpsu_checker u_vrpsu_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_data (m_read_data),
    .m_mem_addr  (m_mem_addr),
    .m_mem_write (m_mem_write),
    .m_mem_read  (m_mem_read)
);

`default_nettype wire

/* sim/video_register_port_scroll_unit_test.sv */
// Testbench of the video register port and scroll unit: directed and random
// register accesses and render events, checked against a scoreboard model.
// Depends on vrpsu_pkg and video_register_port_scroll_unit from rtl.
module video_register_port_scroll_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_STEPS = 1300;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] mem_byte;
        logic [2:0] status_bits;
    } step_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [13:0] mem_addr;
        logic        mem_write;
        logic        mem_read;
        logic        nmi_pulse;
        logic [14:0] cur_addr;
        logic [2:0]  fine_scroll_x;
    } result_t;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = '0;
    logic [2:0]  s_reg_index = '0;
    logic [7:0]  s_write_data = '0;
    logic [7:0]  s_mem_byte = '0;
    logic [2:0]  s_status_bits = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_read_data;
    logic [13:0] m_mem_addr;
    logic        m_mem_write;
    logic        m_mem_read;
    logic        m_nmi_pulse;
    logic [14:0] m_cur_addr;
    logic [2:0]  m_fine_scroll_x;

    step_t   pending_steps[$];
    result_t expected_results[$];
    int      total_steps = 0;
    int      accepted_steps = 0;
    int      mismatch_count = 0;
    int      cycle_count = 0;

    // Shadow copy of the register file and scroll state.
    logic [7:0]  ctrl_shadow;
    logic [7:0]  mask_shadow;
    logic [2:0]  flags_shadow;
    logic [7:0]  data_buffer;
    logic        toggle_shadow;
    logic [14:0] t_addr;
    logic [14:0] v_addr;
    logic [2:0]  fine_x_shadow;
    logic [7:0]  oam_ptr;
    logic [7:0]  oam_shadow [256];

    video_register_port_scroll_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_reg_index    (s_reg_index),
        .s_write_data   (s_write_data),
        .s_mem_byte     (s_mem_byte),
        .s_status_bits  (s_status_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_mem_addr     (m_mem_addr),
        .m_mem_write    (m_mem_write),
        .m_mem_read     (m_mem_read),
        .m_nmi_pulse    (m_nmi_pulse),
        .m_cur_addr     (m_cur_addr),
        .m_fine_scroll_x(m_fine_scroll_x)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_shadow();
        ctrl_shadow   = '0;
        mask_shadow   = '0;
        flags_shadow  = '0;
        data_buffer   = '0;
        toggle_shadow = 1'b0;
        t_addr        = '0;
        v_addr        = '0;
        fine_x_shadow = '0;
        oam_ptr       = '0;
        foreach (oam_shadow[i]) oam_shadow[i] = '0;
    endfunction

    function automatic logic [14:0] data_port_step();
        return ctrl_shadow[2] ? vrpsu_pkg::ADDR_STEP_ROW : vrpsu_pkg::ADDR_STEP_BYTE;
    endfunction

    // Applies one step to the shadow state and returns the result it causes.
    function automatic result_t predict_step(step_t st);
        result_t r;
        logic    rendering;
        logic [4:0] cy;
        r = '0;
        rendering = mask_shadow[3] | mask_shadow[4];
        case (st.action)
            vrpsu_pkg::ACT_READ: begin
                case (st.reg_index)
                    vrpsu_pkg::REG_STATUS: begin
                        r.read_data = {flags_shadow, data_buffer[4:0]};
                        flags_shadow[2] = 1'b0;
                        toggle_shadow = 1'b0;
                    end
                    vrpsu_pkg::REG_ATTR_DATA: r.read_data = oam_shadow[oam_ptr];
                    vrpsu_pkg::REG_DATA: begin
                        r.mem_addr = v_addr[13:0];
                        r.mem_read = 1'b1;
                        // Palette reads skip the one-step delay of the buffer.
                        r.read_data = (v_addr[13:0] >= vrpsu_pkg::PALETTE_BASE)
                                      ? st.mem_byte : data_buffer;
                        data_buffer = st.mem_byte;
                        v_addr = v_addr + data_port_step();
                    end
                    default: ;
                endcase
            end
            vrpsu_pkg::ACT_WRITE: begin
                case (st.reg_index)
                    vrpsu_pkg::REG_CONTROL: begin
                        ctrl_shadow = st.write_data;
                        t_addr[11:10] = st.write_data[1:0];
                    end
                    vrpsu_pkg::REG_MASK:      mask_shadow = st.write_data;
                    vrpsu_pkg::REG_ATTR_ADDR: oam_ptr = st.write_data;
                    vrpsu_pkg::REG_ATTR_DATA: begin
                        oam_shadow[oam_ptr] = st.write_data;
                        oam_ptr = oam_ptr + 8'd1;
                    end
                    vrpsu_pkg::REG_SCROLL: begin
                        if (!toggle_shadow) begin
                            fine_x_shadow = st.write_data[2:0];
                            t_addr[4:0] = st.write_data[7:3];
                        end else begin
                            t_addr[14:12] = st.write_data[2:0];
                            t_addr[9:5] = st.write_data[7:3];
                        end
                        toggle_shadow = ~toggle_shadow;
                    end
                    vrpsu_pkg::REG_ADDRESS: begin
                        if (!toggle_shadow) begin
                            t_addr[13:8] = st.write_data[5:0];
                            t_addr[14] = 1'b0;
                        end else begin
                            t_addr[7:0] = st.write_data;
                            v_addr = t_addr;
                        end
                        toggle_shadow = ~toggle_shadow;
                    end
                    vrpsu_pkg::REG_DATA: begin
                        r.mem_addr = v_addr[13:0];
                        r.mem_write = 1'b1;
                        v_addr = v_addr + data_port_step();
                    end
                    default: ;
                endcase
            end
            vrpsu_pkg::ACT_INC_X: begin
                if (rendering) begin
                    if (v_addr[4:0] == vrpsu_pkg::COARSE_MAX) begin
                        v_addr[4:0] = '0;
                        v_addr[10] = ~v_addr[10];
                    end else begin
                        v_addr[4:0] = v_addr[4:0] + 5'd1;
                    end
                end
            end
            vrpsu_pkg::ACT_INC_Y: begin
                if (rendering) begin
                    if (v_addr[14:12] != vrpsu_pkg::FINE_Y_MAX) begin
                        v_addr[14:12] = v_addr[14:12] + 3'd1;
                    end else begin
                        v_addr[14:12] = '0;
                        cy = v_addr[9:5];
                        if (cy == vrpsu_pkg::COARSE_Y_LAST_ROW) begin
                            cy = '0;
                            v_addr[11] = ~v_addr[11];
                        end else if (cy == vrpsu_pkg::COARSE_MAX) begin
                            cy = '0;
                        end else begin
                            cy = cy + 5'd1;
                        end
                        v_addr[9:5] = cy;
                    end
                end
            end
            vrpsu_pkg::ACT_COPY_X: begin
                if (rendering) begin
                    v_addr[10] = t_addr[10];
                    v_addr[4:0] = t_addr[4:0];
                end
            end
            vrpsu_pkg::ACT_COPY_Y: begin
                if (rendering) begin
                    v_addr[14:11] = t_addr[14:11];
                    v_addr[9:5] = t_addr[9:5];
                end
            end
            vrpsu_pkg::ACT_SET_STAT: begin
                r.nmi_pulse = st.status_bits[2] & ctrl_shadow[7];
                flags_shadow = flags_shadow | st.status_bits;
            end
            default: flags_shadow = flags_shadow & ~st.status_bits;
        endcase
        r.cur_addr = v_addr;
        r.fine_scroll_x = fine_x_shadow;
        return r;
    endfunction

    function automatic void add_step(logic [2:0] act, logic [2:0] idx, logic [7:0] wd,
                                     logic [7:0] mb, logic [2:0] sb);
        step_t st;
        st.action = act;
        st.reg_index = idx;
        st.write_data = wd;
        st.mem_byte = mb;
        st.status_bits = sb;
        pending_steps.push_back(st);
    endfunction

    function automatic void add_access(logic [2:0] act, logic [2:0] idx, logic [7:0] wd);
        add_step(act, idx, wd, 8'($urandom), 3'($urandom));
    endfunction

    function automatic void build_directed();
        // Rendering is still off for the first increment.
        add_access(vrpsu_pkg::ACT_INC_X, vrpsu_pkg::REG_CONTROL, 8'h00);
        add_step(vrpsu_pkg::ACT_SET_STAT, vrpsu_pkg::REG_CONTROL, 8'h00, 8'h00, 3'b111);
        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_CONTROL, 8'h80);
        add_step(vrpsu_pkg::ACT_SET_STAT, vrpsu_pkg::REG_CONTROL, 8'h00, 8'h00, 3'b100);
        add_access(vrpsu_pkg::ACT_READ, vrpsu_pkg::REG_STATUS, 8'h00);
        add_step(vrpsu_pkg::ACT_CLEAR_STAT, vrpsu_pkg::REG_CONTROL, 8'h00, 8'h00, 3'b111);
        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_STATUS, 8'hFF);
        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_MASK, 8'h18);
        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_ADDRESS, 8'hFF);
        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_ADDRESS, 8'hFF);
        add_step(vrpsu_pkg::ACT_READ, vrpsu_pkg::REG_DATA, 8'h00, 8'hAB, 3'b000);
        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_DATA, 8'h55);
        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_CONTROL, 8'h04);
        add_step(vrpsu_pkg::ACT_READ, vrpsu_pkg::REG_DATA, 8'h00, 8'h12, 3'b000);
        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_SCROLL, 8'hFF);
        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_SCROLL, 8'hEF);
        add_access(vrpsu_pkg::ACT_COPY_X, vrpsu_pkg::REG_CONTROL, 8'h00);
        add_access(vrpsu_pkg::ACT_COPY_Y, vrpsu_pkg::REG_CONTROL, 8'h00);
        add_access(vrpsu_pkg::ACT_INC_X, vrpsu_pkg::REG_CONTROL, 8'h00);
        add_access(vrpsu_pkg::ACT_INC_Y, vrpsu_pkg::REG_CONTROL, 8'h00);
        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_ATTR_ADDR, 8'hFF);
        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_ATTR_DATA, 8'h5A);
        add_access(vrpsu_pkg::ACT_READ, vrpsu_pkg::REG_ATTR_DATA, 8'h00);
        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_ATTR_ADDR, 8'hFF);
        add_access(vrpsu_pkg::ACT_READ, vrpsu_pkg::REG_ATTR_DATA, 8'h00);
    endfunction

    // Mostly short, well-formed programming sequences with random content;
    // the rest is fully random noise.
    function automatic void build_random();
        int goal;
        int n;
        logic [7:0] wd;
        goal = pending_steps.size() + RANDOM_STEPS;
        while (pending_steps.size() < goal) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    add_access(vrpsu_pkg::ACT_READ, vrpsu_pkg::REG_STATUS, 8'($urandom));
                    add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_SCROLL, 8'($urandom));
                    add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_SCROLL, 8'($urandom));
                    add_access(vrpsu_pkg::ACT_COPY_X, 3'($urandom), 8'($urandom));
                    add_access(vrpsu_pkg::ACT_COPY_Y, 3'($urandom), 8'($urandom));
                    n = $urandom_range(4, 32);
                    repeat (n) begin
                        add_access($urandom_range(0, 3) == 0 ? vrpsu_pkg::ACT_INC_Y
                                                             : vrpsu_pkg::ACT_INC_X,
                                   3'($urandom), 8'($urandom));
                    end
                end
                2, 3: begin
                    add_access(vrpsu_pkg::ACT_READ, vrpsu_pkg::REG_STATUS, 8'($urandom));
                    wd = ($urandom_range(0, 2) == 0) ? 8'h3F : 8'($urandom);
                    add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_ADDRESS, wd);
                    add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_ADDRESS, 8'($urandom));
                    n = $urandom_range(1, 12);
                    repeat (n) begin
                        add_access($urandom_range(0, 1) ? vrpsu_pkg::ACT_READ
                                                        : vrpsu_pkg::ACT_WRITE,
                                   vrpsu_pkg::REG_DATA, 8'($urandom));
                    end
                end
                4: begin
                    wd = 8'($urandom);
                    add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_ATTR_ADDR, wd);
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_ATTR_DATA,
                                   8'($urandom));
                    end
                    add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_ATTR_ADDR, wd);
                    repeat (n) begin
                        add_access(vrpsu_pkg::ACT_READ, vrpsu_pkg::REG_ATTR_DATA,
                                   8'($urandom));
                    end
                end
                5: begin
                    wd = 8'($urandom);
                    if ($urandom_range(0, 3) == 0) wd[4:3] = 2'b00;
                    add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_MASK, wd);
                    add_access(vrpsu_pkg::ACT_WRITE, vrpsu_pkg::REG_CONTROL, 8'($urandom));
                end
                6: begin
                    add_access(vrpsu_pkg::ACT_SET_STAT, 3'($urandom), 8'($urandom));
                    add_access(vrpsu_pkg::ACT_READ, vrpsu_pkg::REG_STATUS, 8'($urandom));
                    add_access(vrpsu_pkg::ACT_CLEAR_STAT, 3'($urandom), 8'($urandom));
                end
                default: begin
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        add_access(3'($urandom), 3'($urandom), 8'($urandom));
                    end
                end
            endcase
        end
    endfunction

    // Sender: bursts of random length with random gaps after each burst.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin : drive_steps
        logic  next_valid;
        step_t st;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                st = {s_action, s_reg_index, s_write_data, s_mem_byte, s_status_bits};
                expected_results.push_back(predict_step(st));
                accepted_steps++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    next_valid = 1'b0;
                end else if (pending_steps.size() != 0) begin
                    st = pending_steps.pop_front();
                    next_valid = 1'b1;
                    s_action      <= st.action;
                    s_reg_index   <= st.reg_index;
                    s_write_data  <= st.write_data;
                    s_mem_byte    <= st.mem_byte;
                    s_status_bits <= st.status_bits;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    next_valid = 1'b0;
                end
            end
            s_valid <= next_valid;
        end
    end

    // Receiver: a stall pattern that changes at random intervals, plus a
    // long hold-off now and then so the output register fills and s_ready drops.
    rx_mode_t rx_mode = RX_FREE;
    int       mode_left = 0;
    int       hold_left = 0;
    int       next_hold_at = 300;
    logic [1:0] rx_phase = '0;

    always @(posedge aclk) begin : drive_ready
        logic next_ready;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_left == 0 && accepted_steps >= next_hold_at) begin
                hold_left = LONG_HOLD;
                next_hold_at = next_hold_at + 700;
            end
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            rx_phase = rx_phase + 2'd1;
            if (hold_left != 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:   next_ready = 1'b1;
                    RX_COIN:   next_ready = 1'($urandom_range(0, 1));
                    RX_SPARSE: next_ready = (rx_phase == 2'd0);
                    default:   next_ready = ($urandom_range(0, 3) != 0);
                endcase
            end
            m_ready <= next_ready;
        end
    end

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no step waiting for it");
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("read_data", 16'(want.read_data), 16'(m_read_data));
                check_field("mem_addr", 16'(want.mem_addr), 16'(m_mem_addr));
                check_field("mem_write", 16'(want.mem_write), 16'(m_mem_write));
                check_field("mem_read", 16'(want.mem_read), 16'(m_mem_read));
                check_field("nmi_pulse", 16'(want.nmi_pulse), 16'(m_nmi_pulse));
                check_field("cur_addr", 16'(want.cur_addr), 16'(m_cur_addr));
                check_field("fine_scroll_x", 16'(want.fine_scroll_x),
                            16'(m_fine_scroll_x));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        clear_shadow();
        build_directed();
        build_random();
        total_steps = pending_steps.size();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        while (accepted_steps != total_steps || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
